// File: design/rbpr_pkg.sv
// Package with shared types and constants of the reference-bit page replacer.
package rbpr_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int PAGE_W  = 16;
    localparam int INDEX_W = 2;
    localparam int COUNT_W = 32;

    // Saturation value of the hit and fault totals.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Defaults of the top-level parameters.
    localparam int FRAMES_DEF    = 4;
    localparam int PAGE_BITS_DEF = 16;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } rbpr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } rbpr_cmd_t;

endpackage

// File: design/rbpr_in_if.sv
// Input channel interface carrying one page reference per transfer.
interface rbpr_in_if;
    logic                        valid;
    logic                        ready;
    logic [rbpr_pkg::PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

// File: design/rbpr_out_if.sv
// Output channel interface carrying one lookup result per transfer.
interface rbpr_out_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [rbpr_pkg::INDEX_W-1:0] frame_index;
    logic                         evicted_valid;
    logic [rbpr_pkg::PAGE_W-1:0]  evicted_page;
    logic [rbpr_pkg::COUNT_W-1:0] hit_total;
    logic [rbpr_pkg::COUNT_W-1:0] fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output hit_total, output fault_total,
                    input ready);
    modport sink (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input hit_total, input fault_total,
                  output ready);
endinterface

// File: design/rbpr_ctrl.sv
// Controller state machine that sequences capture, compare and commit of each reference.
module rbpr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output rbpr_pkg::rbpr_cmd_t cmd
);

    rbpr_pkg::rbpr_state_t state_reg;
    rbpr_pkg::rbpr_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbpr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rbpr_pkg::ST_LOOKUP;
                end
            end
            rbpr_pkg::ST_LOOKUP:
            begin
                state_next = rbpr_pkg::ST_COMMIT;
            end
            rbpr_pkg::ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = rbpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: handshake and datapath commands.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            rbpr_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            rbpr_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            rbpr_pkg::ST_COMMIT:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag follows commits and output transfers.
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbpr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: design/rbpr_datapath.sv
// Datapath with the frame table, reference bits, victim pick, totals and result register.
module rbpr_datapath #(
    parameter int FRAMES    = rbpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = rbpr_pkg::PAGE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rbpr_pkg::rbpr_cmd_t          cmd,
    input  logic [rbpr_pkg::PAGE_W-1:0]  page_number,
    output logic                         hit,
    output logic [rbpr_pkg::INDEX_W-1:0] frame_index,
    output logic                         evicted_valid,
    output logic [rbpr_pkg::PAGE_W-1:0]  evicted_page,
    output logic [rbpr_pkg::COUNT_W-1:0] hit_total,
    output logic [rbpr_pkg::COUNT_W-1:0] fault_total
);

    // Only the low PAGE_BITS bits of a reference take part, at most the PAGE_W bits of the field.
    localparam int KEY_W = (PAGE_BITS < rbpr_pkg::PAGE_W) ? PAGE_BITS : rbpr_pkg::PAGE_W;
    localparam int IDX_W = $clog2(FRAMES);

    // Increment of the totals at their full width.
    localparam logic [rbpr_pkg::COUNT_W-1:0] COUNT_ONE = 1;

    logic [KEY_W-1:0]            page_reg;
    logic [FRAMES-1:0]           match_reg;
    logic [KEY_W-1:0]            frame_page_reg [FRAMES];
    logic [FRAMES-1:0]           frame_valid_reg;
    logic [FRAMES-1:0]           ref_bits_reg;
    logic [FRAMES-1:0]           ref_bits_next;
    logic [rbpr_pkg::COUNT_W-1:0] hit_cnt_reg;
    logic [rbpr_pkg::COUNT_W-1:0] fault_cnt_reg;
    logic                        hit_out_reg;
    logic [rbpr_pkg::INDEX_W-1:0] index_out_reg;
    logic                        ev_valid_reg;
    logic [rbpr_pkg::PAGE_W-1:0] ev_page_reg;

    logic                        hit_any;
    logic [IDX_W-1:0]            hit_idx;
    logic [FRAMES-1:0]           clear_vec;
    logic                        have_clear;
    logic [IDX_W-1:0]            clear_idx;
    logic [IDX_W-1:0]            victim_idx;
    logic [IDX_W-1:0]            sel_idx;
    logic [IDX_W+1:0]            sel_idx_ext;
    logic                        victim_valid;
    logic [rbpr_pkg::PAGE_W-1:0] victim_page;

    // Capture the reference on an input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg <= page_number[KEY_W-1:0];
        end
    end

    // Compare the reference against every occupied frame.
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int j = 0; j < FRAMES; j++)
            begin
                match_reg[j] <= frame_valid_reg[j] && (frame_page_reg[j] == page_reg);
            end
        end
    end

    // Priority picks: lowest matching frame and lowest frame with a clear bit.
    assign hit_any    = |match_reg;
    assign clear_vec  = ~ref_bits_reg;
    assign have_clear = |clear_vec;

    always_comb
    begin
        hit_idx   = '0;
        clear_idx = '0;
        for (int j = FRAMES - 1; j >= 0; j--)
        begin
            if (match_reg[j])
            begin
                hit_idx = IDX_W'(j);
            end
            if (clear_vec[j])
            begin
                clear_idx = IDX_W'(j);
            end
        end
    end

    // With every bit set, frame 0 is the victim.
    assign victim_idx   = have_clear ? clear_idx : '0;
    assign sel_idx      = hit_any ? hit_idx : victim_idx;
    assign sel_idx_ext  = {2'b00, sel_idx};
    assign victim_valid = frame_valid_reg[victim_idx];
    assign victim_page  = victim_valid ? rbpr_pkg::PAGE_W'(frame_page_reg[victim_idx]) : '0;

    // Reference bits: cleared when all were set on a fault, then the chosen frame is marked.
    always_comb
    begin
        if (hit_any || have_clear)
        begin
            ref_bits_next = ref_bits_reg;
        end
        else
        begin
            ref_bits_next = '0;
        end
        ref_bits_next[sel_idx] = 1'b1;
    end

    // Frame table and totals update at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            ref_bits_reg    <= '0;
            hit_cnt_reg     <= '0;
            fault_cnt_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            ref_bits_reg <= ref_bits_next;
            if (hit_any)
            begin
                if (hit_cnt_reg != rbpr_pkg::COUNT_MAX)
                begin
                    hit_cnt_reg <= hit_cnt_reg + COUNT_ONE;
                end
            end
            else
            begin
                frame_valid_reg[victim_idx] <= 1'b1;
                if (fault_cnt_reg != rbpr_pkg::COUNT_MAX)
                begin
                    fault_cnt_reg <= fault_cnt_reg + COUNT_ONE;
                end
            end
        end
    end

    // Page numbers of the frames carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_any)
        begin
            frame_page_reg[victim_idx] <= page_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_out_reg   <= hit_any;
            index_out_reg <= sel_idx_ext[rbpr_pkg::INDEX_W-1:0];
            ev_valid_reg  <= !hit_any && victim_valid;
            ev_page_reg   <= hit_any ? '0 : victim_page;
        end
    end

    assign hit           = hit_out_reg;
    assign frame_index   = index_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign hit_total     = hit_cnt_reg;
    assign fault_total   = fault_cnt_reg;

endmodule

// File: design/reference_bit_page_replacer_core.sv
// Top level of the reference-bit page replacer: controller, datapath and checks.
//
// A not-recently-used page replacer over FRAMES fully associative frames. Each
// reference on req yields one result on rsp: hit or fault, the frame used, the
// page evicted from an occupied frame, and the saturating hit and fault totals
// after this reference. An item passes three steps from input transfer to
// result (capture, compare against all frames, commit of victim pick and
// table update), and the commit waits while the result register is full.
// The input takes no new item until the one before it is committed. A
// result waiting on rsp does not block the next input transfer, only its
// commit. Reset empties all frames and clears all reference bits and totals
// at once, so no clearing pass follows reset.
module reference_bit_page_replacer_core #(
    parameter int FRAMES    = rbpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = rbpr_pkg::PAGE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rbpr_in_if.sink    req,
    rbpr_out_if.source rsp
);

    rbpr_pkg::rbpr_cmd_t cmd;

    // Controller.
    rbpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    // Datapath.
    rbpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .page_number   (req.page_number),
        .hit           (rsp.hit),
        .frame_index   (rsp.frame_index),
        .evicted_valid (rsp.evicted_valid),
        .evicted_page  (rsp.evicted_page),
        .hit_total     (rsp.hit_total),
        .fault_total   (rsp.fault_total)
    );

    // A commit never overwrites a result that is still waiting.
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("commit while result register held an untaken result");

    // A captured reference is compared in the following cycle.
    a_capture_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.lookup)
        else $error("capture not followed by lookup");

    // A commit always presents a result in the next cycle.
    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit did not raise result valid");

    // No input transfer is taken while a reference is in flight.
    a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lookup || cmd.commit) |-> !req.ready)
        else $error("input ready while a reference is in flight");

endmodule
